FILE: rtl/dzss_pkg.sv
// distance zone speed selector: shared types and constants
// zone codes, configuration register indexes, reset values, register bundle
// no dependencies
package dzss_pkg;

	// field widths fixed by the interface
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned SPEED_W = 6;
	localparam int unsigned ZONE_W  = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// zone codes; the unused code behaves like far
	typedef enum logic [ZONE_W-1:0] {
		ZONE_NEAR = 2'd0,
		ZONE_MID  = 2'd1,
		ZONE_FAR  = 2'd2
	} zone_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_LOW_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_HIGH_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NEAR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MID      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FAR      = 3'd6;

	// register reset values
	localparam logic [DIST_W-1:0]  RST_NEAR_LIMIT     = 16'd330;
	localparam logic [DIST_W-1:0]  RST_MID_LOW_LIMIT  = 16'd370;
	localparam logic [DIST_W-1:0]  RST_MID_HIGH_LIMIT = 16'd520;
	localparam logic [DIST_W-1:0]  RST_FAR_LIMIT      = 16'd580;
	localparam logic [SPEED_W-1:0] RST_SPEED_NEAR     = 6'd16;
	localparam logic [SPEED_W-1:0] RST_SPEED_MID      = 6'd21;
	localparam logic [SPEED_W-1:0] RST_SPEED_FAR      = 6'd26;

	// configuration register bundle
	typedef struct packed {
		logic [DIST_W-1:0]  near_limit;
		logic [DIST_W-1:0]  mid_low_limit;
		logic [DIST_W-1:0]  mid_high_limit;
		logic [DIST_W-1:0]  far_limit;
		logic [SPEED_W-1:0] speed_near;
		logic [SPEED_W-1:0] speed_mid;
		logic [SPEED_W-1:0] speed_far;
	} cfg_regs_t;

	// zone decision for one sample
	typedef struct packed {
		zone_t              zone_sel;
		zone_t              zone_next;
		logic [SPEED_W-1:0] speed;
	} zone_dec_t;

endpackage

FILE: rtl/distance_zone_speed_selector_unit.sv
// distance zone speed selector: top level with registers and handshakes
// holds configuration, filter state, input stage and result register
// depends on dzss_pkg and dzss_datapath
//
// Usage:
//   in channel   : in_valid/in_ready, one distance_cm sample per beat
//   out channel  : out_valid/out_ready, one beat per sample with target_speed,
//                  speed_zone and smoothed_distance
//   cfg channel  : cfg_valid/cfg_ready with cfg_index and cfg_data; always
//                  ready, write only while no sample is in flight
// An input beat passes through the input register, then the filter/zone logic
// into the result register, and leaves as the output beat.
// Throughput is one sample per cycle while the receiver accepts results; the
// filter state and zone feed back combinationally, bounded by the reciprocal divide by five.
// Reset clears the filter to zero, the zone to near, both stage valids, and
// loads the default limits and speeds.
// When the receiver stalls, the result register holds its beat and the
// input register keeps one more sample; in_ready drops once both are full.
module distance_zone_speed_selector_unit #(
	parameter int unsigned FRACTION_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dzss_pkg::DIST_W-1:0]       distance_cm,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dzss_pkg::SPEED_W-1:0]      target_speed,
	output logic [dzss_pkg::ZONE_W-1:0]       speed_zone,
	output logic [dzss_pkg::DIST_W-1:0]       smoothed_distance,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dzss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dzss_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dzss_pkg::*;

	localparam int unsigned FILT_W = DIST_W + FRACTION_BITS;

	cfg_regs_t            cfg_q;
	logic [FILT_W-1:0]    filt_q;
	zone_t                zone_q;
	logic                 valid_s1;
	logic [DIST_W-1:0]    dist_s1;
	logic                 valid_s2;
	logic [SPEED_W-1:0]   speed_s2;
	zone_t                zone_s2;
	logic [DIST_W-1:0]    smooth_s2;
	logic [FILT_W-1:0]    filt_new;
	zone_dec_t            dec;
	logic                 advance;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_limit     <= RST_NEAR_LIMIT;
			cfg_q.mid_low_limit  <= RST_MID_LOW_LIMIT;
			cfg_q.mid_high_limit <= RST_MID_HIGH_LIMIT;
			cfg_q.far_limit      <= RST_FAR_LIMIT;
			cfg_q.speed_near     <= RST_SPEED_NEAR;
			cfg_q.speed_mid      <= RST_SPEED_MID;
			cfg_q.speed_far      <= RST_SPEED_FAR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NEAR_LIMIT:     cfg_q.near_limit     <= cfg_data;
				CFG_MID_LOW_LIMIT:  cfg_q.mid_low_limit  <= cfg_data;
				CFG_MID_HIGH_LIMIT: cfg_q.mid_high_limit <= cfg_data;
				CFG_FAR_LIMIT:      cfg_q.far_limit      <= cfg_data;
				CFG_SPEED_NEAR:     cfg_q.speed_near     <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_MID:      cfg_q.speed_mid      <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_FAR:      cfg_q.speed_far      <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshakes: s1 moves into the result register when it is free
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dist_s1 <= distance_cm;
		end
	end

	// filter and zone logic
	dzss_datapath #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.distance_cm (dist_s1),
		.filt_old    (filt_q),
		.zone_cur    (zone_q),
		.cfg         (cfg_q),
		.filt_new    (filt_new),
		.dec         (dec)
	);

	// filter state and stored zone update once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			zone_q <= ZONE_NEAR;
		end else if (advance) begin
			filt_q <= filt_new;
			zone_q <= dec.zone_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			speed_s2  <= dec.speed;
			zone_s2   <= dec.zone_sel;
			smooth_s2 <= DIST_W'(filt_new >> FRACTION_BITS);
		end
	end

	assign out_valid         = valid_s2;
	assign target_speed      = speed_s2;
	assign speed_zone        = zone_s2;
	assign smoothed_distance = smooth_s2;

endmodule

FILE: rtl/dzss_datapath.sv
// distance zone speed selector: filter update and zone decision for one sample
// exponential average with divide by five via reciprocal multiply, band tests
// depends on dzss_pkg
module dzss_datapath #(
	parameter int unsigned FRACTION_BITS = 4
) (
	input  logic [dzss_pkg::DIST_W-1:0]          distance_cm,
	input  logic [dzss_pkg::DIST_W+FRACTION_BITS-1:0] filt_old,
	input  dzss_pkg::zone_t                      zone_cur,
	input  dzss_pkg::cfg_regs_t                  cfg,
	output logic [dzss_pkg::DIST_W+FRACTION_BITS-1:0] filt_new,
	output dzss_pkg::zone_dec_t                  dec
);
	import dzss_pkg::*;

	localparam int unsigned FILT_W = DIST_W + FRACTION_BITS;
	// 3*old + 2*sample needs three extra bits
	localparam int unsigned SUM_W  = FILT_W + 3;
	localparam int unsigned DIV_SH = SUM_W + 2;
	localparam logic [SUM_W-1:0] RECIP = SUM_W'(((64'd1 << DIV_SH) + 64'd4) / 64'd5);
	localparam logic [FILT_W-1:0] FILT_MAX = {FILT_W{1'b1}};

	logic [FILT_W-1:0]  sample;
	logic [SUM_W-1:0]   sum;
	logic [2*SUM_W-1:0] prod;
	logic [SUM_W-1:0]   quot;
	logic [FILT_W-1:0]  f;
	logic [FILT_W-1:0]  t_near;
	logic [FILT_W-1:0]  t_mlo;
	logic [FILT_W-1:0]  t_mhi;
	logic [FILT_W-1:0]  t_far;
	logic               lt_near;
	logic               gt_mlo;
	logic               lt_mlo;
	logic               gt_mhi;
	logic               lt_mhi;
	logic               gt_far;
	zone_t              sel;
	zone_t              nxt;

	// (6*old + 4*sample)/10 == (3*old + 2*sample)/5
	assign sample = FILT_W'(distance_cm) << FRACTION_BITS;
	assign sum    = (SUM_W'(filt_old) << 1) + SUM_W'(filt_old) + (SUM_W'(sample) << 1);
	assign prod   = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP);
	assign quot   = SUM_W'(prod >> DIV_SH);

	// saturate at the top of the state width
	always_comb begin
		if (quot > SUM_W'(FILT_MAX)) begin
			f = FILT_MAX;
		end else begin
			f = quot[FILT_W-1:0];
		end
	end
	assign filt_new = f;

	// limits aligned to the fixed-point format
	assign t_near = FILT_W'(cfg.near_limit) << FRACTION_BITS;
	assign t_mlo  = FILT_W'(cfg.mid_low_limit) << FRACTION_BITS;
	assign t_mhi  = FILT_W'(cfg.mid_high_limit) << FRACTION_BITS;
	assign t_far  = FILT_W'(cfg.far_limit) << FRACTION_BITS;

	assign lt_near = f < t_near;
	assign gt_mlo  = f > t_mlo;
	assign lt_mlo  = f < t_mlo;
	assign gt_mhi  = f > t_mhi;
	assign lt_mhi  = f < t_mhi;
	assign gt_far  = f > t_far;

	// stage one: forced zone from band tests, else keep
	always_comb begin
		if (lt_near) begin
			sel = ZONE_NEAR;
		end else if (gt_mlo && lt_mhi) begin
			sel = ZONE_MID;
		end else if (gt_far) begin
			sel = ZONE_FAR;
		end else begin
			sel = zone_cur;
		end
	end

	// stage two: hysteresis move for the next sample
	always_comb begin
		nxt = sel;
		case (sel)
			ZONE_NEAR: begin
				if (gt_mhi) begin
					nxt = ZONE_FAR;
				end else if (gt_mlo) begin
					nxt = ZONE_MID;
				end
			end
			ZONE_MID: begin
				if (gt_far) begin
					nxt = ZONE_FAR;
				end else if (lt_near) begin
					nxt = ZONE_NEAR;
				end
			end
			default: begin
				if (lt_mlo) begin
					nxt = ZONE_NEAR;
				end else if (lt_mhi) begin
					nxt = ZONE_MID;
				end else begin
					nxt = ZONE_FAR;
				end
			end
		endcase
	end

	// speed of the stage-one zone
	always_comb begin
		dec.zone_sel  = sel;
		dec.zone_next = nxt;
		case (sel)
			ZONE_NEAR: dec.speed = cfg.speed_near;
			ZONE_MID:  dec.speed = cfg.speed_mid;
			default:   dec.speed = cfg.speed_far;
		endcase
	end

endmodule
